/* rtl/iff_pkg.sv */
// Shared types, constants and helpers for the integer field formatter.
package iff_pkg;

  localparam int CNT_W = 9;

  localparam logic [1:0] MODE_OCT = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;

  localparam int FL_ZERO  = 0;
  localparam int FL_LEFT  = 1;
  localparam int FL_PLUS  = 2;
  localparam int FL_BLANK = 3;
  localparam int FL_ALT   = 4;
  localparam int FL_CAPS  = 5;

  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  value_size;
    logic        is_signed;
    logic [1:0]  mode;
    logic [5:0]  flags;
    logic [6:0]  width;
    logic [5:0]  precision;
    logic        has_precision;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_t;

  // Region boundaries of one field, in character positions
  typedef struct packed {
    cnt_t       b_sign;
    cnt_t       b_pfx;
    cnt_t       b_zero;
    cnt_t       b_dig;
    cnt_t       b_tail;
    cnt_t       total;
    cnt_t       nd;
    logic [7:0] sign_ch;
    logic [7:0] x_ch;
    logic       upper;
  } desc_t;

  typedef struct packed {
    logic       we;
    cnt_t       addr;
    logic [3:0] digit;
    logic       push;
    desc_t      desc;
  } wr_t;

  typedef struct packed {
    logic pop;
    cnt_t addr;
  } rd_t;

  typedef enum logic {F_IDLE, F_CONV} fstate_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

/* rtl/iff_front.sv */
// Front end: takes an item, forms the magnitude and converts it to digits.
module iff_front import iff_pkg::*; #(
  parameter int MAX_CHARS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_data,
  input  logic full,
  output logic busy,
  output wr_t  wr
);

  fstate_t     state_r, state_nxt;
  logic [63:0] t_r, t_nxt;
  logic [63:0] q_r, q_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [3:0]  sub_r, sub_nxt;
  cnt_t        nd_r, nd_nxt;
  logic        dec_r, hex_r, neg_r, plus_r, space_r, alt_r, upper_r, left_r, zero_r;
  cnt_t        w_r, prec_r;

  logic        accept;
  logic [63:0] ext, mag;
  logic        neg_c;
  cnt_t        w_c, prec_c;
  logic [7:0]  q8, r8;
  logic [15:0] prod;
  logic [3:0]  qd, dig;
  logic        dig_done, fin;
  cnt_t        ndf, nde, sl, pl, nchar, pad;

  assign busy   = (state_r != F_IDLE) || full;
  assign accept = start && !busy;

  always_comb begin
    case (in_data.value_size)
      SZ_8:    ext = {{56{in_data.is_signed & in_data.value[7]}}, in_data.value[7:0]};
      SZ_16:   ext = {{48{in_data.is_signed & in_data.value[15]}}, in_data.value[15:0]};
      SZ_32:   ext = {{32{in_data.is_signed & in_data.value[31]}}, in_data.value[31:0]};
      default: ext = in_data.value;
    endcase
    neg_c = in_data.is_signed & ext[63];
    mag   = neg_c ? (64'd0 - ext) : ext;
    w_c   = (cnt_t'(in_data.width) > cnt_t'(MAX_CHARS)) ? cnt_t'(MAX_CHARS)
                                                        : cnt_t'(in_data.width);
    prec_c = in_data.has_precision ? cnt_t'(in_data.precision) : '0;
    if (prec_c > cnt_t'(MAX_CHARS - 3)) prec_c = cnt_t'(MAX_CHARS - 3);
  end

  // Digit step: decimal by long division by ten, one nibble a cycle; octal and hex by shifts
  always_comb begin
    q8   = {rem_r, t_r[63:60]};
    prod = {8'b0, q8} * 16'd205;
    qd   = prod[14:11];
    r8   = q8 - ({4'b0, qd} * 8'd10);
    q_nxt   = {q_r[59:0], qd};
    rem_nxt = rem_r;
    sub_nxt = sub_r;
    if (dec_r) begin
      dig      = r8[3:0];
      dig_done = (sub_r == 4'hf);
      t_nxt    = dig_done ? q_nxt : {t_r[59:0], 4'b0};
      rem_nxt  = dig_done ? 4'd0 : r8[3:0];
      sub_nxt  = sub_r + 4'd1;
    end else if (hex_r) begin
      dig      = t_r[3:0];
      dig_done = 1'b1;
      t_nxt    = {4'b0, t_r[63:4]};
    end else begin
      dig      = {1'b0, t_r[2:0]};
      dig_done = 1'b1;
      t_nxt    = {3'b0, t_r[63:3]};
    end
    fin = (state_r == F_CONV) && dig_done &&
          ((t_nxt == 64'd0) || (nd_r == cnt_t'(MAX_CHARS - 1)));
  end

  // Field layout once the digit count is known
  always_comb begin
    ndf   = nd_r + cnt_t'(1);
    nde   = (ndf > prec_r) ? ndf : prec_r;
    sl    = cnt_t'(neg_r | plus_r | space_r);
    pl    = !alt_r ? '0 : (hex_r ? cnt_t'(2) : (dec_r ? '0 : cnt_t'(1)));
    nchar = nde + sl + pl;
    pad   = (w_r > nchar) ? (w_r - nchar) : '0;
    wr.desc.b_sign  = (!left_r && !zero_r) ? pad : '0;
    wr.desc.b_pfx   = wr.desc.b_sign + sl;
    wr.desc.b_zero  = wr.desc.b_pfx + pl;
    wr.desc.b_dig   = wr.desc.b_zero + ((!left_r && zero_r) ? pad : '0);
    wr.desc.b_tail  = wr.desc.b_dig + nde;
    wr.desc.total   = nchar + pad;
    wr.desc.nd      = ndf;
    wr.desc.sign_ch = neg_r ? CH_MINUS : (plus_r ? CH_PLUS : CH_SPACE);
    wr.desc.x_ch    = upper_r ? CH_UX : CH_LX;
    wr.desc.upper   = upper_r;
    wr.we    = (state_r == F_CONV) && dig_done;
    wr.addr  = nd_r;
    wr.digit = dig;
    wr.push  = fin;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_CONV;
      F_CONV:  if (fin) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    nd_nxt = nd_r;
    if (accept) begin
      nd_nxt = '0;
    end else if ((state_r == F_CONV) && dig_done) begin
      nd_nxt = nd_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nd_r <= nd_nxt;
    if (accept) begin
      t_r     <= mag;
      q_r     <= '0;
      rem_r   <= '0;
      sub_r   <= '0;
      dec_r   <= (in_data.mode == MODE_DEC);
      hex_r   <= (in_data.mode != MODE_DEC) && (in_data.mode != MODE_OCT);
      neg_r   <= neg_c;
      plus_r  <= in_data.flags[FL_PLUS];
      space_r <= in_data.flags[FL_BLANK];
      alt_r   <= in_data.flags[FL_ALT];
      upper_r <= in_data.flags[FL_CAPS];
      left_r  <= in_data.flags[FL_LEFT];
      zero_r  <= in_data.flags[FL_ZERO];
      w_r     <= w_c;
      prec_r  <= prec_c;
    end else if (state_r == F_CONV) begin
      t_r   <= t_nxt;
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      sub_r <= sub_nxt;
    end
  end

endmodule

/* rtl/iff_queue.sv */
// Two-entry field queue with its digit memory, one bank per entry.
module iff_queue import iff_pkg::*; #(
  parameter int MAX_CHARS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  wr_t        wr,
  input  rd_t        rd,
  output logic       full,
  output logic       empty,
  output desc_t      head,
  output logic [3:0] rd_data
);

  localparam int AW = $clog2(MAX_CHARS);

  logic [3:0]    mem [2**(AW+1)];
  desc_t         desc_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic [3:0]    rd_data_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = desc_r[rd_ptr_r];
  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) mem[{wr_ptr_r, wr.addr[AW-1:0]}] <= wr.digit;
    rd_data_r <= mem[{rd_ptr_r, rd.addr[AW-1:0]}];
    if (wr.push) desc_r[wr_ptr_r] <= wr.desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr.push) wr_ptr_r <= !wr_ptr_r;
      if (rd.pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, wr.push} - {1'b0, rd.pop};
    end
  end

endmodule

/* rtl/iff_back.sv */
// Back end: walks the field position by position and emits one character a cycle.
module iff_back import iff_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       empty,
  input  desc_t      head,
  input  logic [3:0] rd_data,
  output rd_t        rd,
  output logic       out_valid,
  output out_t       out_data
);

  cnt_t       p_r;
  logic       s1_v_r, s1_mem_r, s1_last_r, s1_upper_r;
  logic [7:0] s1_lit_r;
  logic       out_valid_r;
  out_t       out_r;

  logic       go, is_mem, is_last;
  logic [7:0] lit;
  cnt_t       idx;

  always_comb begin
    go      = !empty;
    is_mem  = 1'b0;
    lit     = CH_SPACE;
    idx     = head.b_tail - cnt_t'(1) - p_r;
    is_last = (p_r == head.total - cnt_t'(1));
    if (p_r < head.b_sign) begin
      lit = CH_SPACE;
    end else if (p_r < head.b_pfx) begin
      lit = head.sign_ch;
    end else if (p_r < head.b_zero) begin
      lit = (p_r == head.b_pfx) ? CH_ZERO : head.x_ch;
    end else if (p_r < head.b_dig) begin
      lit = CH_ZERO;
    end else if (p_r < head.b_tail) begin
      // precision zeros sit above the converted digits
      is_mem = (idx < head.nd);
      lit    = CH_ZERO;
    end
    rd.addr = idx;
    rd.pop  = go && is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r         <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) p_r <= is_last ? '0 : (p_r + cnt_t'(1));
      s1_v_r      <= go;
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mem_r   <= is_mem;
    s1_lit_r   <= lit;
    s1_last_r  <= is_last;
    s1_upper_r <= head.upper;
    out_r.out_char <= s1_mem_r ? digit_char(rd_data, s1_upper_r) : s1_lit_r;
    out_r.last     <= s1_last_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/integer_field_formatter_top.sv */
// Integer field formatter top level: front converter, field queue, character emitter.
// Conversion: one digit per cycle in octal or hex; in decimal each digit comes from a
//   nibble-serial division by ten of the whole value, up to 20 digits for 64 bits.
// Emission: one character per cycle, max(width, field length) characters; each field
//   passes stage s1 and the output register; emission overlaps the next conversion.
// busy is high while converting or while both queue entries hold unsent fields.
// Synchronous active-low reset empties the queue; the receiver cannot stall out_valid.
module integer_field_formatter_top import iff_pkg::*; #(
  parameter int MAX_CHARS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_data,
  output logic busy,
  output logic out_valid,
  output out_t out_data
);

  wr_t        wr;
  rd_t        rd;
  logic       full, empty;
  desc_t      head;
  logic [3:0] rd_data;

  // front: accept and convert to digits
  iff_front #(.MAX_CHARS(MAX_CHARS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .full    (full),
    .busy    (busy),
    .wr      (wr)
  );

  // queue: field layout plus digit memory, one bank per entry
  iff_queue #(.MAX_CHARS(MAX_CHARS)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd      (rd),
    .full    (full),
    .empty   (empty),
    .head    (head),
    .rd_data (rd_data)
  );

  // back: character emitter
  iff_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .rd_data   (rd_data),
    .rd        (rd),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a transfer in starts conversion, so the block reads busy next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy low after accepted transfer");

  // the front only finishes into a free queue entry
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr.push |-> !full) else $error("field pushed into full queue");

  // the emitter only retires a field that is queued
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rd.pop |-> !empty) else $error("field popped from empty queue");

endmodule

/* sim/tb.sv */
// Testbench for the integer field formatter: directed and random fields checked per character.
module tb import iff_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIELD_MAX   = 64;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 141;

  // Base selector for hex is not in the package; mode three also means hex.
  localparam logic [1:0] MODE_HEX = 2'd2;
  localparam logic [1:0] MODE_HEX_ALIAS = 2'd3;
  localparam logic [1:0] SZ_64 = 2'd3;

  // Expected characters of all accepted fields, in emission order.
  class field_scoreboard;
    out_t pending_chars[$];
    int   errors;
    int   fields;
    int   chars_checked;

    function new();
      errors = 0;
      fields = 0;
      chars_checked = 0;
    endfunction

    // Build the printf-style field for one accepted argument.
    function void note_field(in_t a);
      logic [63:0] v, mask, t;
      int unsigned radix, bits;
      logic neg, zpad, left, plus, space, alt, upper;
      logic [7:0] digs[$];
      logic [7:0] line[$];
      logic [7:0] d;
      int w, prec, nd, nchar;
      zpad  = a.flags[FL_ZERO];
      left  = a.flags[FL_LEFT];
      plus  = a.flags[FL_PLUS];
      space = a.flags[FL_BLANK];
      alt   = a.flags[FL_ALT];
      upper = a.flags[FL_CAPS];
      radix = (a.mode == MODE_OCT) ? 8 : (a.mode == MODE_DEC) ? 10 : 16;
      bits  = 8 << a.value_size;
      w     = (a.width > FIELD_MAX) ? FIELD_MAX : int'(a.width);
      prec  = a.has_precision ? int'(a.precision) : 0;
      if (prec > FIELD_MAX - 3) prec = FIELD_MAX - 3;
      v = a.value;
      neg = 1'b0;
      if (bits < 64) begin
        mask = (64'd1 << bits) - 64'd1;
        v = v & mask;
        if (a.is_signed && v[bits-1]) v = v | ~mask;
      end
      if (a.is_signed && v[63]) begin
        v = 64'd0 - v;
        neg = 1'b1;
      end
      t = v;
      do begin
        d = 8'(t % radix);
        digs.push_front(d < 10 ? CH_ZERO + d : (upper ? CH_UA : CH_LA) + d - 8'd10);
        t = t / radix;
      end while (t != 0);
      while (digs.size() < prec) digs.push_front(CH_ZERO);
      nd = digs.size();
      nchar = nd + ((neg || plus || space) ? 1 : 0);
      if (alt) nchar += (radix == 16) ? 2 : (radix == 8) ? 1 : 0;
      if (!left && !zpad) for (int i = nchar; i < w; i++) line.push_back(CH_SPACE);
      if (neg) line.push_back(CH_MINUS);
      else if (plus) line.push_back(CH_PLUS);
      else if (space) line.push_back(CH_SPACE);
      if (alt && radix == 16) begin
        line.push_back(CH_ZERO);
        line.push_back(upper ? CH_UX : CH_LX);
      end else if (alt && radix == 8) begin
        line.push_back(CH_ZERO);
      end
      if (!left && zpad) for (int i = nchar; i < w; i++) line.push_back(CH_ZERO);
      foreach (digs[i]) line.push_back(digs[i]);
      if (left) for (int i = nchar; i < w; i++) line.push_back(CH_SPACE);
      foreach (line[i]) begin
        if (i < FIELD_MAX) pending_chars.push_back('{out_char: line[i],
            last: (i == line.size() - 1 || i == FIELD_MAX - 1)});
      end
      fields++;
    endfunction

    function void check_char(out_t got);
      out_t want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h/%b",
                 $time, got.out_char, got.last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.out_char !== want.out_char) begin
        $display("%0t: out_char mismatch: expected %h, actual %h",
                 $time, want.out_char, got.out_char);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %b, actual %b",
                 $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_valid;
  in_t  in_data;
  out_t out_data;
  field_scoreboard fields_sb;
  int idle_cycles;

  integer_field_formatter_top #(.MAX_CHARS(FIELD_MAX)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .busy(busy), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output side: every strobed character is a transfer, checked in order.
  always @(posedge clk) begin
    if (rst_n && out_valid) fields_sb.check_char(out_data);
  end

  // Watchdog: counts cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // After an optional random gap with start low, present one argument and hold it until accepted.
  task automatic send_field(in_t a);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= a;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    fields_sb.note_field(a);
  endtask

  task automatic drain_fields();
    start <= 1'b0;
    while (fields_sb.pending_chars.size() != 0) @(posedge clk);
  endtask

  function automatic in_t make_arg(logic [63:0] v, logic [1:0] sz, logic sgn,
                                   logic [1:0] md, logic [5:0] fl, logic [6:0] w,
                                   logic [5:0] p, logic hp);
    in_t a;
    a.value = v; a.value_size = sz; a.is_signed = sgn; a.mode = md;
    a.flags = fl; a.width = w; a.precision = p; a.has_precision = hp;
    return a;
  endfunction

  // Random argument; widths and precisions are biased toward the edges.
  function automatic in_t random_arg();
    in_t a;
    a.value = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: a.value = a.value >> $urandom_range(0, 63);
      1: a.value = {64{a.value[0]}} ^ (a.value >> $urandom_range(32, 63));
      default: ;
    endcase
    a.value_size = 2'($urandom_range(0, 3));
    a.is_signed  = 1'($urandom_range(0, 1));
    a.mode       = 2'($urandom_range(0, 3));
    a.flags      = 6'($urandom_range(0, 63));
    a.width      = 7'(($urandom_range(0, 7) == 0) ? $urandom_range(60, 127)
                                                  : $urandom_range(0, 24));
    a.precision  = 6'(($urandom_range(0, 7) == 0) ? $urandom_range(55, 63)
                                                  : $urandom_range(0, 24));
    a.has_precision = 1'($urandom_range(0, 1));
    return a;
  endfunction

  initial begin
    fields_sb = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, each base, each flag, and the named corner cases.
    send_field(make_arg(64'd0, SZ_64, 1'b0, MODE_DEC, 6'd0, 7'd0, 6'd0, 1'b1));   // zero, prec 0
    send_field(make_arg(64'd0, SZ_8, 1'b0, MODE_HEX, 6'b010000, 7'd6, 6'd0, 1'b0)); // 0x on zero
    send_field(make_arg(64'd0, SZ_16, 1'b0, MODE_OCT, 6'b010001, 7'd5, 6'd0, 1'b0));
    send_field(make_arg('1, SZ_64, 1'b0, MODE_DEC, 6'd0, 7'd0, 6'd0, 1'b0));      // max unsigned
    send_field(make_arg('1, SZ_64, 1'b0, MODE_OCT, 6'b010000, 7'd0, 6'd0, 1'b0));
    send_field(make_arg('1, SZ_64, 1'b0, MODE_HEX_ALIAS, 6'b110000, 7'd0, 6'd0, 1'b0));
    send_field(make_arg(64'h8000_0000_0000_0000, SZ_64, 1'b1, MODE_DEC, 6'd0,
                        7'd0, 6'd0, 1'b0));                                        // most negative
    send_field(make_arg(64'h0000_0000_0000_0080, SZ_8, 1'b1, MODE_DEC, 6'd0, 7'd6, 6'd0, 1'b0));
    send_field(make_arg(64'hffff_ffff_ffff_8000, SZ_16, 1'b1, MODE_HEX, 6'b000001,
                        7'd10, 6'd0, 1'b0));
    send_field(make_arg(64'h1234_5678_8000_0000, SZ_32, 1'b1, MODE_OCT, 6'b000010,
                        7'd20, 6'd0, 1'b0));
    send_field(make_arg(64'd42, SZ_32, 1'b1, MODE_DEC, 6'b000100, 7'd8, 6'd5, 1'b1));
    send_field(make_arg(64'd42, SZ_32, 1'b0, MODE_DEC, 6'b001000, 7'd8, 6'd0, 1'b0));
    send_field(make_arg(64'd42, SZ_32, 1'b0, MODE_DEC, 6'b001001, 7'd8, 6'd4, 1'b1)); // prec+zero
    send_field(make_arg(64'hbeef, SZ_16, 1'b0, MODE_HEX, 6'b000011, 7'd12, 6'd0, 1'b0));
    send_field(make_arg(64'hbeef, SZ_16, 1'b0, MODE_HEX, 6'b111111, 7'd12, 6'd0, 1'b0));
    send_field(make_arg(64'd7, SZ_8, 1'b0, MODE_OCT, 6'd0, 7'd127, 6'd0, 1'b0));  // width saturates
    send_field(make_arg(64'd7, SZ_8, 1'b1, MODE_DEC, 6'b000100, 7'd64, 6'd63, 1'b1));
    send_field(make_arg('1, SZ_64, 1'b1, MODE_HEX, 6'b010101, 7'd64, 6'd63, 1'b1));
    send_field(make_arg(64'h00ab_cdef_0123_4567, SZ_64, 1'b0, MODE_HEX, 6'b100000,
                        7'd0, 6'd0, 1'b0));

    // Pause until everything is out, so the next field starts from an empty queue.
    drain_fields();

    repeat (RANDOM_ITEMS) send_field(random_arg());

    drain_fields();
    repeat (400) @(posedge clk);

    $display("Covered %0d fields and %0d characters across all bases, sizes and flags.",
             fields_sb.fields, fields_sb.chars_checked);
    if (fields_sb.errors == 0 && fields_sb.pending_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d characters missing",
               fields_sb.errors, fields_sb.pending_chars.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
